FILE: rtl/core/linear_probe_hash_table_macros.svh
// Assertion macros for the linear probing hash table.
// Included by the RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define LPHT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lpht assertion failed");
`define LPHT_NEVER(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) not (prop)) \
    else $error("lpht forbidden condition seen");
`else
`define LPHT_ASSERT(name, prop)
`define LPHT_NEVER(name, prop)
`endif

`endif

FILE: rtl/core/lpht_pkg.sv
// Shared types and codes for the linear probing hash table.
// No dependencies; used by lpht_ctrl, lpht_datapath and the top level.
package lpht_pkg;

  localparam int unsigned FUNC_FIELD_W   = 2;
  localparam int unsigned KEY_FIELD_W    = 16;
  localparam int unsigned SLOT_FIELD_W   = 4;
  localparam int unsigned STATUS_FIELD_W = 2;

  typedef enum logic [FUNC_FIELD_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [STATUS_FIELD_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [FUNC_FIELD_W-1:0] func;
    logic [KEY_FIELD_W-1:0]  key;
  } in_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0]   slot;
    logic [STATUS_FIELD_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic    load;
    logic    hash_step;
    logic    probe_start;
    logic    probe_step;
    logic    sweep_start;
    logic    sweep_step;
    logic    ins_write;
    logic    res_set;
    logic    res_use_slot;
    status_e res_status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic sweep_last;
    logic slot_valid;
    logic key_match;
    logic lap_end;
  } sts_t;

endpackage

FILE: rtl/core/lpht_datapath.sv
// Datapath: key register, reciprocal home-slot reduction, slot memory, probe pointer, result regs.
// Depends on lpht_pkg; driven by lpht_ctrl through cmd_t, reports through sts_t.
module lpht_datapath #(
  parameter int unsigned TABLE_SIZE = 16,
  parameter int unsigned KEY_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [lpht_pkg::KEY_FIELD_W-1:0]    in_key_i,
  input  lpht_pkg::cmd_t                      cmd_i,
  output lpht_pkg::sts_t                      sts_o,
  output lpht_pkg::out_t                      out_data_o
);

  localparam int unsigned SW = $clog2(TABLE_SIZE);
  localparam int unsigned KW = (KEY_BITS < lpht_pkg::KEY_FIELD_W) ? KEY_BITS
                                                                  : lpht_pkg::KEY_FIELD_W;
  localparam int unsigned RS = KW + SW;
  localparam int unsigned PW = 2 * KW + 2;
  localparam logic [KW+1:0] RECIP_C =
    (KW + 2)'(((64'd1 << RS) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

  logic [KW-1:0] key_q, key_d;
  logic [KW:0]   quo_q, quo_d;
  logic          hcnt_q, hcnt_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [SW-1:0] ptr_q, ptr_d;
  logic [SW-1:0] pcnt_q, pcnt_d;
  logic [KW:0]   rd_q;
  lpht_pkg::out_t res_q, res_d;
  lpht_pkg::out_t out_q, out_d;

  logic [KW:0]   mem [TABLE_SIZE];
  logic          wr_en;
  logic [KW:0]   wr_data;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] ptr_nxt;
  logic [PW-1:0] prod;
  logic [KW:0]   quo_nxt;
  logic [KW:0]   rem_t;
  logic [SW+lpht_pkg::SLOT_FIELD_W-1:0] slot_wide;

  // key / TABLE_SIZE by reciprocal multiply, then key - quotient * TABLE_SIZE
  assign prod      = PW'(in_key_i[KW-1:0]) * PW'(RECIP_C);
  assign quo_nxt   = (KW + 1)'(prod >> RS);
  assign rem_t     = (KW + 1)'(key_q) - quo_q * (KW + 1)'(TABLE_SIZE);
  assign ptr_nxt   = (ptr_q == SW'(TABLE_SIZE - 1)) ? '0 : ptr_q + SW'(1);
  assign slot_wide = (SW + lpht_pkg::SLOT_FIELD_W)'(ptr_q);

  always_comb begin
    key_d   = key_q;
    quo_d   = quo_q;
    hcnt_d  = hcnt_q;
    rem_d   = rem_q;
    ptr_d   = ptr_q;
    pcnt_d  = pcnt_q;
    rd_addr = ptr_q;
    res_d   = res_q;
    out_d   = out_q;
    if (cmd_i.load) begin
      key_d  = in_key_i[KW-1:0];
      quo_d  = quo_nxt;
      hcnt_d = 1'b0;
    end
    if (cmd_i.hash_step) begin
      rem_d  = SW'(rem_t);
      hcnt_d = 1'b1;
    end
    if (cmd_i.probe_start) begin
      rd_addr = rem_q;
      ptr_d   = rem_q;
      pcnt_d  = '0;
    end
    if (cmd_i.probe_step) begin
      rd_addr = ptr_nxt;
      ptr_d   = ptr_nxt;
      pcnt_d  = pcnt_q + SW'(1);
    end
    if (cmd_i.sweep_start) begin
      ptr_d = '0;
    end
    if (cmd_i.sweep_step) begin
      ptr_d = ptr_nxt;
    end
    if (cmd_i.res_set) begin
      res_d.status = cmd_i.res_status;
      res_d.slot   = cmd_i.res_use_slot ? slot_wide[lpht_pkg::SLOT_FIELD_W-1:0] : '0;
    end
    if (cmd_i.out_load) begin
      out_d = res_q;
    end
  end

  assign wr_en   = cmd_i.sweep_step | cmd_i.ins_write;
  assign wr_data = cmd_i.ins_write ? {1'b1, key_q} : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ptr_q] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= 1'b0;
      ptr_q  <= '0;
      pcnt_q <= '0;
    end else begin
      hcnt_q <= hcnt_d;
      ptr_q  <= ptr_d;
      pcnt_q <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign sts_o.hash_done  = hcnt_q;
  assign sts_o.sweep_last = (ptr_q == SW'(TABLE_SIZE - 1));
  assign sts_o.slot_valid = rd_q[KW];
  assign sts_o.key_match  = (rd_q[KW-1:0] == key_q);
  assign sts_o.lap_end    = (pcnt_q == SW'(TABLE_SIZE - 1));
  assign out_data_o       = out_q;

endmodule

FILE: rtl/core/lpht_ctrl.sv
// Controller FSM: sequences init sweep, clear sweep, key reduction, probing and result handoff.
// Depends on lpht_pkg and linear_probe_hash_table_macros.svh; commands lpht_datapath.
`include "linear_probe_hash_table_macros.svh"

module lpht_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lpht_pkg::FUNC_FIELD_W-1:0]  in_func_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lpht_pkg::cmd_t                     cmd_o,
  input  lpht_pkg::sts_t                     sts_i
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_PROBE = 6'b001000,
    S_CLEAR = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [lpht_pkg::FUNC_FIELD_W-1:0] op_q, op_d;
  logic out_vld_q, out_vld_d;
  logic in_acc;
  logic out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.res_status = lpht_pkg::ST_OK;
    out_vld_d = out_vld_q && out_stall_i;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          op_d       = in_func_i;
          case (in_func_i)
            lpht_pkg::OP_CLEAR: begin
              cmd_o.sweep_start = 1'b1;
              state_d = S_CLEAR;
            end
            lpht_pkg::OP_INSERT, lpht_pkg::OP_SEARCH: begin
              state_d = S_HASH;
            end
            default: begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = lpht_pkg::ST_NOT_FOUND;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.probe_start = 1'b1;
          state_d = S_PROBE;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_PROBE: begin
        if (op_q == lpht_pkg::OP_INSERT) begin
          if (!sts_i.slot_valid) begin
            cmd_o.ins_write    = 1'b1;
            cmd_o.res_set      = 1'b1;
            cmd_o.res_use_slot = 1'b1;
            cmd_o.res_status   = lpht_pkg::ST_OK;
            state_d = S_RESP;
          end else if (sts_i.lap_end) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = lpht_pkg::ST_FULL;
            state_d = S_RESP;
          end else begin
            cmd_o.probe_step = 1'b1;
          end
        end else begin
          if (!sts_i.slot_valid || (!sts_i.key_match && sts_i.lap_end)) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = lpht_pkg::ST_NOT_FOUND;
            state_d = S_RESP;
          end else if (sts_i.key_match) begin
            cmd_o.res_set      = 1'b1;
            cmd_o.res_use_slot = 1'b1;
            cmd_o.res_status   = lpht_pkg::ST_OK;
            state_d = S_RESP;
          end else begin
            cmd_o.probe_step = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = lpht_pkg::ST_OK;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      op_q      <= lpht_pkg::OP_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

  `LPHT_NEVER(a_insert_only_into_empty, cmd_o.ins_write && sts_i.slot_valid)
  `LPHT_NEVER(a_no_probe_past_lap, cmd_o.probe_step && sts_i.lap_end)
  `LPHT_ASSERT(a_out_load_when_free, cmd_o.out_load |-> (!out_vld_q || !out_stall_i))
  `LPHT_ASSERT(a_accept_leaves_idle, in_acc |=> (state_q != S_IDLE))
  `LPHT_ASSERT(a_clear_ends_in_resp, (state_q == S_CLEAR && sts_i.sweep_last) |=> (state_q == S_RESP))

endmodule

FILE: rtl/core/linear_probe_hash_table.sv
// Top level of the linear probing hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_datapath.
//
//   port group   dir  handshake             beat
//   in_*         in   in_valid_i/in_stall_o  in_t  {func, key}
//   out_*        out  out_valid_o/out_stall_i out_t {slot, status}
//
// Insert/search: accept, key reduction, home-slot read, then probing with one slot memory
//   read per step, up to TABLE_SIZE slots, then the result handoff, which waits while the
//   output register holds a stalled beat. Clear: a sweep with one write per slot, then the
//   handoff; unused selector: handoff only. in_stall_o is high until the handoff is done.
// After reset a sweep over every slot clears the valid marks; in_stall_o is high meanwhile.
// One beat may wait in the output register while the next item is accepted and worked.
module linear_probe_hash_table #(
  parameter int unsigned TABLE_SIZE = 16,
  parameter int unsigned KEY_BITS   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lpht_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lpht_pkg::out_t out_data_o
);

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_func_i   (in_data_i.func),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_key_i   (in_data_i.key),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
